[rtl/assert_macros.svh]
// assertion helpers shared by the rtl modules
// both expect a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define RVE_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rve assertion failed");

// condition must never hold at a clock edge outside reset
`define RVE_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rve forbidden condition seen");

`endif

[rtl/rve_pkg.sv]
// ----------------------------------------------------------------------------
// rve_pkg
// types, constants and register codes of the rotary value edit controller
// ----------------------------------------------------------------------------
package rve_pkg;

    // encoder pulses that make one detent step
    localparam int PULSES_PER_DETENT = 2;

    localparam int TEMPO_W = 16;
    localparam int TIME_W  = 32;
    localparam int STEP_W  = 18;
    localparam int REM_W   = 4;
    localparam int MAG_W   = 17;

    // reciprocal for the detent division, floor(2^DIV_SHIFT / pulses)
    localparam int DIV_SHIFT = 20;
    localparam logic [20:0] DIV_RECIP = 21'((1 << DIV_SHIFT) / PULSES_PER_DETENT);
    localparam logic [3:0]  PPD4      = 4'(PULSES_PER_DETENT);

    // request kinds
    localparam logic ACT_POLL = 1'b0;
    localparam logic ACT_SYNC = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_TEMPO_MIN  = 2'd0;
    localparam logic [1:0] CFG_TEMPO_MAX  = 2'd1;
    localparam logic [1:0] CFG_TEMPO_INC  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

    localparam logic [15:0] TEMPO_MIN_RST = 16'd320;
    localparam logic [15:0] TEMPO_MAX_RST = 16'd4800;
    localparam logic [15:0] TEMPO_INC_RST = 16'd16;
    localparam logic [15:0] TIMEOUT_RST   = 16'd5000;

    typedef struct packed {
        logic               action;
        logic signed [15:0] pulse_delta;
        logic               switch_level;
        logic               interval_page;
        logic [31:0]        now_ms;
        logic [15:0]        sync_tempo;
    } in_t;

    typedef struct packed {
        logic               tempo_changed;
        logic               edit_confirmed;
        logic               edit_cancelled;
        logic               transport_toggle;
        logic [15:0]        reported_tempo;
        logic signed [15:0] interval_steps;
    } out_t;

    typedef struct packed {
        logic [15:0] tempo_min;
        logic [15:0] tempo_max;
        logic [15:0] tempo_increment;
        logic [15:0] edit_timeout_ms;
    } cfg_t;

    // request after detent conversion
    typedef struct packed {
        logic                     action;
        logic signed [STEP_W-1:0] steps;
        logic                     switch_level;
        logic                     interval_page;
        logic [TIME_W-1:0]        now_ms;
        logic [TEMPO_W-1:0]       sync_tempo;
    } det_t;

endpackage

[rtl/rve_detent.sv]
// ----------------------------------------------------------------------------
// rve_detent
// turns negated pulse counts into whole detent steps, keeps the remainder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rve_detent
    import rve_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  in_t  req,
    output det_t det
);

    logic signed [REM_W-1:0]  rem_reg;
    logic signed [REM_W-1:0]  rem_next;
    logic signed [STEP_W-1:0] r;
    logic                     neg;
    logic [MAG_W-1:0]         a;
    logic [37:0]              prod;
    logic [MAG_W-1:0]         q_est;
    logic [3:0]               rem_est;
    logic                     corr;
    logic [MAG_W-1:0]         q;
    logic [3:0]               rem_mag;
    logic signed [STEP_W-1:0] q_s;
    logic signed [STEP_W-1:0] steps;

    always_comb
    begin
        r       = STEP_W'(rem_reg) - STEP_W'(req.pulse_delta);
        neg     = r[STEP_W-1];
        a       = neg ? MAG_W'(-r) : MAG_W'(r);
        // truncating division by magnitude, estimate is low by at most one
        prod    = 38'(a) * 38'(DIV_RECIP);
        q_est   = MAG_W'(prod >> DIV_SHIFT);
        rem_est = 4'(a[3:0] - 4'(q_est[3:0] * PPD4));
        corr    = (rem_est >= PPD4);
        q       = q_est + MAG_W'(corr);
        rem_mag = corr ? 4'(rem_est - PPD4) : rem_est;
        q_s     = {1'b0, q};
        steps   = neg ? STEP_W'(-q_s) : q_s;
        rem_next = neg ? REM_W'(-$signed({1'b0, rem_mag})) : $signed(rem_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (en && (req.action == ACT_POLL))
        begin
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        det.action        = req.action;
        det.steps         = (req.action == ACT_POLL) ? steps : '0;
        det.switch_level  = req.switch_level;
        det.interval_page = req.interval_page;
        det.now_ms        = req.now_ms;
        det.sync_tempo    = req.sync_tempo;
    end

    `RVE_ASSERT(a_rem_range, (rem_reg < PULSES_PER_DETENT) && (rem_reg > -PULSES_PER_DETENT))

endmodule

[rtl/rve_tempo.sv]
// ----------------------------------------------------------------------------
// rve_tempo
// edit mode, tempo sync and clamp, confirm, cancel timeout, transport toggle and interval steps
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rve_tempo
    import rve_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  det_t det,
    input  cfg_t cfg,
    output out_t res
);

    logic                 editing_reg;
    logic                 rotated_reg;
    logic [TEMPO_W-1:0]   conf_tempo_reg;
    logic [TEMPO_W-1:0]   edit_tempo_reg;
    logic [TIME_W-1:0]    start_reg;
    logic                 last_sw_reg;

    logic                 editing_next;
    logic                 rotated_next;
    logic [TEMPO_W-1:0]   conf_tempo_next;
    logic [TEMPO_W-1:0]   edit_tempo_next;
    logic [TIME_W-1:0]    start_next;
    logic                 last_sw_next;

    localparam logic signed [STEP_W-1:0] ISTEP_MAX = 18'sd32767;
    localparam logic signed [STEP_W-1:0] ISTEP_MIN = -18'sd32768;

    logic signed [34:0]   prod;
    logic signed [34:0]   t_raw;
    logic signed [34:0]   t_lo;
    logic signed [34:0]   t_clamp;
    logic [TEMPO_W-1:0]   base;
    logic                 moved;
    logic [TIME_W-1:0]    elapsed;

    always_comb
    begin
        editing_next    = editing_reg;
        rotated_next    = rotated_reg;
        conf_tempo_next = conf_tempo_reg;
        edit_tempo_next = edit_tempo_reg;
        start_next      = start_reg;
        last_sw_next    = last_sw_reg;
        res             = '0;

        moved   = (det.steps != '0);
        base    = editing_reg ? edit_tempo_reg : conf_tempo_reg;
        prod    = 35'(det.steps) * 35'($signed({1'b0, cfg.tempo_increment}));
        t_raw   = $signed({19'b0, base}) + prod;
        t_lo    = (t_raw < $signed({19'b0, cfg.tempo_min})) ? $signed({19'b0, cfg.tempo_min})
                                                           : t_raw;
        t_clamp = (t_lo > $signed({19'b0, cfg.tempo_max})) ? $signed({19'b0, cfg.tempo_max})
                                                          : t_lo;
        elapsed = '0;

        if (det.action == ACT_SYNC)
        begin
            if (!editing_reg)
            begin
                conf_tempo_next = det.sync_tempo;
                edit_tempo_next = det.sync_tempo;
            end
        end
        else
        begin
            // rotation
            if (moved && det.interval_page)
            begin
                priority if (det.steps > ISTEP_MAX)
                    res.interval_steps = 16'sh7fff;
                else if (det.steps < ISTEP_MIN)
                    res.interval_steps = 16'sh8000;
                else
                    res.interval_steps = det.steps[15:0];
            end
            else if (moved)
            begin
                editing_next       = 1'b1;
                rotated_next       = 1'b1;
                start_next         = det.now_ms;
                edit_tempo_next    = t_clamp[TEMPO_W-1:0];
                res.tempo_changed  = 1'b1;
                res.reported_tempo = t_clamp[TEMPO_W-1:0];
            end

            // switch falling edge
            if (last_sw_reg && !det.switch_level && !det.interval_page)
            begin
                if (editing_next && rotated_next)
                begin
                    conf_tempo_next    = edit_tempo_next;
                    editing_next       = 1'b0;
                    rotated_next       = 1'b0;
                    res.edit_confirmed = 1'b1;
                    res.reported_tempo = edit_tempo_next;
                end
                else if (!rotated_next)
                begin
                    res.transport_toggle = 1'b1;
                end
            end
            last_sw_next = det.switch_level;

            // idle timeout, elapsed wraps modulo 2^32
            elapsed = det.now_ms - start_next;
            if (!det.interval_page && editing_next &&
                (elapsed >= {16'b0, cfg.edit_timeout_ms}))
            begin
                editing_next       = 1'b0;
                rotated_next       = 1'b0;
                edit_tempo_next    = conf_tempo_next;
                res.edit_cancelled = 1'b1;
                res.reported_tempo = conf_tempo_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            editing_reg    <= 1'b0;
            rotated_reg    <= 1'b0;
            conf_tempo_reg <= '0;
            edit_tempo_reg <= '0;
            start_reg      <= '0;
            last_sw_reg    <= 1'b1;
        end
        else if (en)
        begin
            editing_reg    <= editing_next;
            rotated_reg    <= rotated_next;
            conf_tempo_reg <= conf_tempo_next;
            edit_tempo_reg <= edit_tempo_next;
            start_reg      <= start_next;
            last_sw_reg    <= last_sw_next;
        end
    end

    // edit mode is only entered by rotation and both leave together
    `RVE_ASSERT(a_edit_rot, editing_reg == rotated_reg)

endmodule

[rtl/rotary_value_edit_controller.sv]
// ----------------------------------------------------------------------------
// rotary_value_edit_controller
// path: a request passes stage one, then stage two, then the result register
// throughput: one request per cycle while the result channel does not stall; the detent
//   remainder loop and the edit state loop each close in their own stage
// reset: rst_n clears all stage valid flags, edit state and remainder, loads register defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotary_value_edit_controller
    import rve_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,

    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,

    // configuration write port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    cfg_t cfg_reg;

    // stage one: registered request
    logic s1_valid_reg;
    in_t  s1_reg;

    // stage two: request with detent steps
    logic s2_valid_reg;
    det_t s2_reg;
    det_t det_comb;

    // result register
    logic out_valid_reg;
    out_t out_reg;
    out_t res_comb;

    logic out_free;
    logic s2_move;
    logic s2_free;
    logic s1_move;
    logic s1_free;

    // each stage advances when the next one is empty or emptying
    assign out_free = !out_valid_reg || out_ready;
    assign s2_move  = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // register writes, taken at any time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tempo_min       <= TEMPO_MIN_RST;
            cfg_reg.tempo_max       <= TEMPO_MAX_RST;
            cfg_reg.tempo_increment <= TEMPO_INC_RST;
            cfg_reg.edit_timeout_ms <= TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TEMPO_MIN: cfg_reg.tempo_min       <= cfg_data;
                CFG_TEMPO_MAX: cfg_reg.tempo_max       <= cfg_data;
                CFG_TEMPO_INC: cfg_reg.tempo_increment <= cfg_data;
                CFG_TIMEOUT:   cfg_reg.edit_timeout_ms <= cfg_data;
                default:       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= in_valid;
            if (s2_free)
                s2_valid_reg <= s1_move;
            if (out_free)
                out_valid_reg <= s2_move;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_reg <= in_data;
        if (s1_move)
            s2_reg <= det_comb;
        if (s2_move)
            out_reg <= res_comb;
    end

    // pulse to detent conversion, remainder updates as the request leaves stage one
    rve_detent u_detent
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (s1_move),
        .req   (s1_reg),
        .det   (det_comb)
    );

    // edit state machine, updates as the request leaves stage two
    rve_tempo u_tempo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (s2_move),
        .det   (s2_reg),
        .cfg   (cfg_reg),
        .res   (res_comb)
    );

    // a confirm leaves edit mode, so a cancel cannot follow in the same request
    `RVE_ASSERT_NEVER(a_conf_cancel, out_valid_reg && out_reg.edit_confirmed && out_reg.edit_cancelled)
    // a stalled result stays in the output register
    `RVE_ASSERT(a_out_hold, (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_reg)))
    // a tempo move and interval steps come from different pages
    `RVE_ASSERT_NEVER(a_page_excl, out_valid_reg && out_reg.tempo_changed && (out_reg.interval_steps != 16'sd0))

endmodule
